// File: src/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the sphere pair separation pipeline.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int CoordW   = 32;
    localparam int DiffW    = 33;
    localparam int RadiusW  = 31;
    localparam int RsumW    = 32;
    localparam int SqW      = 66;
    localparam int MagW     = 33;
    localparam int RemW     = 68;
    localparam int QuotW    = 16;
    localparam int DremW    = 49;
    localparam int GapW     = 34;
    localparam int NormW    = 16;
    localparam int CapReset = 65536;

    localparam logic [0:0] REG_GHOST_CAP = 1'b0;

    typedef struct packed {
        logic [2:0]                neg;
        logic [2:0][DiffW-1:0]     ad;
        logic [RsumW-1:0]          rsum;
    } side_t;

endpackage

// File: src/sps_front.sv
// ----------------------------------------------------------------------------
// sps_front
// Center differences, effective radii, squares and their sum in three stages.
// ----------------------------------------------------------------------------
module sps_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [5:0][sps_pkg::CoordW-1:0] coord,
    input  logic [sps_pkg::RadiusW-1:0]   first_radius,
    input  logic [sps_pkg::RadiusW-1:0]   second_radius,
    input  logic [3:0]                    flags,
    input  logic [sps_pkg::RadiusW-1:0]   cap,
    output logic                          out_valid,
    output logic [sps_pkg::SqW-1:0]       sum_sq,
    output sps_pkg::side_t                side
);

    logic [2:0]                 valid_reg;
    sps_pkg::side_t             s1_reg;
    sps_pkg::side_t             s2_reg;
    sps_pkg::side_t             s3_reg;
    logic [2:0][sps_pkg::SqW-1:0] sq_reg;
    logic [sps_pkg::SqW-1:0]    sum_reg;
    sps_pkg::side_t             s1_next;
    logic [sps_pkg::DiffW-1:0]  d;
    logic [sps_pkg::RadiusW-1:0] r1;
    logic [sps_pkg::RadiusW-1:0] r2;

    always_comb
    begin
        s1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = {coord[i][sps_pkg::CoordW-1], coord[i]}
                - {coord[i+3][sps_pkg::CoordW-1], coord[i+3]};
            s1_next.neg[i] = d[sps_pkg::DiffW-1];
            s1_next.ad[i]  = d[sps_pkg::DiffW-1] ? (~d + 1'b1) : d;
        end
        r1 = (flags[0] && first_radius > cap && !flags[3]) ? cap : first_radius;
        r2 = (flags[1] && second_radius > cap && !flags[2]) ? cap : second_radius;
        s1_next.rsum = {1'b0, r1} + {1'b0, r2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sps_pkg::SqW'(s1_reg.ad[i] * s1_reg.ad[i]);
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign out_valid = valid_reg[2];
    assign sum_sq    = sum_reg;
    assign side      = s3_reg;

endmodule

// File: src/sps_sqrt.sv
// ----------------------------------------------------------------------------
// sps_sqrt
// Pipelined integer square root, one result bit per stage, rounded down.
// ----------------------------------------------------------------------------
module sps_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [sps_pkg::SqW-1:0]     sum_sq,
    input  sps_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [sps_pkg::MagW-1:0]    mag,
    output sps_pkg::side_t              out_side
);

    localparam int Stages = sps_pkg::MagW;

    logic                          valid_reg [Stages+1];
    logic [sps_pkg::RemW-1:0]      rem_reg   [Stages+1];
    logic [sps_pkg::MagW-1:0]      root_reg  [Stages+1];
    sps_pkg::side_t                side_reg  [Stages+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = {{(sps_pkg::RemW-sps_pkg::SqW){1'b0}}, sum_sq};
        root_reg[0]  = '0;
        side_reg[0]  = in_side;
    end

    for (genvar k = 0; k < Stages; k++)
    begin : g_stage
        localparam int B = Stages - 1 - k;
        logic [sps_pkg::RemW-1:0] term;
        always_comb
        begin
            term = ({{(sps_pkg::RemW-sps_pkg::MagW){1'b0}}, root_reg[k]} << (B + 1))
                 | (sps_pkg::RemW'(1) << (2 * B));
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                if (rem_reg[k] >= term)
                begin
                    rem_reg[k+1]  <= rem_reg[k] - term;
                    root_reg[k+1] <= root_reg[k] | (sps_pkg::MagW'(1) << B);
                end
                else
                begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
            end
        end
    end

    assign out_valid = valid_reg[Stages];
    assign mag       = root_reg[Stages];
    assign out_side  = side_reg[Stages];

endmodule

// File: src/sps_div.sv
// ----------------------------------------------------------------------------
// sps_div
// Pipelined restoring division of the three scaled differences by the length.
// ----------------------------------------------------------------------------
module sps_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [sps_pkg::MagW-1:0]           in_mag,
    input  sps_pkg::side_t                     in_side,
    output logic                               out_valid,
    output logic [sps_pkg::MagW-1:0]           out_mag,
    output sps_pkg::side_t                     out_side,
    output logic [2:0][sps_pkg::QuotW-1:0]     quot
);

    localparam int Stages = sps_pkg::QuotW;

    logic                                valid_reg [Stages+1];
    logic [2:0][sps_pkg::DremW-1:0]      rem_reg   [Stages+1];
    logic [2:0][sps_pkg::QuotW-1:0]      q_reg     [Stages+1];
    logic [sps_pkg::MagW-1:0]            mag_reg   [Stages+1];
    sps_pkg::side_t                      side_reg  [Stages+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        mag_reg[0]   = in_mag;
        side_reg[0]  = in_side;
        q_reg[0]     = '0;
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[0][i] = {1'b0, in_side.ad[i], 15'b0};
        end
    end

    for (genvar k = 0; k < Stages; k++)
    begin : g_stage
        localparam int B = Stages - 1 - k;
        logic [sps_pkg::DremW-1:0] term;
        assign term = {{(sps_pkg::DremW-sps_pkg::MagW){1'b0}}, mag_reg[k]} << B;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k+1]  <= mag_reg[k];
                side_reg[k+1] <= side_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[k][i] >= term)
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i] - term;
                        q_reg[k+1][i]   <= q_reg[k][i] | (sps_pkg::QuotW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i];
                        q_reg[k+1][i]   <= q_reg[k][i];
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[Stages];
    assign out_mag   = mag_reg[Stages];
    assign out_side  = side_reg[Stages];
    assign quot      = q_reg[Stages];

endmodule

// File: src/sphere_pair_separation.sv
// ----------------------------------------------------------------------------
// sphere_pair_separation
// Signed surface gap and unit normal between two spheres.
// ----------------------------------------------------------------------------
// While the output is not stalled, one sphere pair enters per clock. The path
// is three front stages, 33 square root stages (one root bit each), 16 divider
// stages (one quotient bit each) and the output register. A stall at the
// output freezes the whole pipeline; nothing is dropped.
module sphere_pair_separation
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x1, y1, z1, x2, y2, z2 (32 each), first_radius, second_radius (31 each)
    input  logic [255:0] s_tdata,
    // first_is_ghost, second_is_ghost, first_is_player, second_is_player
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // gap (34), normal_x, normal_y, normal_z (16 each)
    output logic [87:0]  m_tdata,
    // coincident
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [sps_pkg::RadiusW-1:0]        cap_reg;
    logic                               en;
    logic                               f_valid;
    logic [sps_pkg::SqW-1:0]            f_sum;
    sps_pkg::side_t                     f_side;
    logic                               q_valid;
    logic [sps_pkg::MagW-1:0]           q_mag;
    sps_pkg::side_t                     q_side;
    logic                               d_valid;
    logic [sps_pkg::MagW-1:0]           d_mag;
    sps_pkg::side_t                     d_side;
    logic [2:0][sps_pkg::QuotW-1:0]     d_quot;
    logic                               m_tvalid_reg;
    logic [87:0]                        m_tdata_reg;
    logic [87:0]                        m_tdata_next;
    logic                               m_tuser_reg;
    logic                               coin;
    logic [sps_pkg::NormW-1:0]          nrm;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == sps_pkg::REG_GHOST_CAP) ? {1'b0, cap_reg} : 32'd0;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= sps_pkg::RadiusW'(sps_pkg::CapReset);
        end
        else if (psel && penable && pwrite && paddr[2] == sps_pkg::REG_GHOST_CAP)
        begin
            cap_reg <= pwdata[sps_pkg::RadiusW-1:0];
        end
    end

    sps_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .coord         (s_tdata[191:0]),
        .first_radius  (s_tdata[222:192]),
        .second_radius (s_tdata[253:223]),
        .flags         (s_tuser),
        .cap           (cap_reg),
        .out_valid     (f_valid),
        .sum_sq        (f_sum),
        .side          (f_side)
    );

    sps_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .sum_sq    (f_sum),
        .in_side   (f_side),
        .out_valid (q_valid),
        .mag       (q_mag),
        .out_side  (q_side)
    );

    sps_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_mag    (q_mag),
        .in_side   (q_side),
        .out_valid (d_valid),
        .out_mag   (d_mag),
        .out_side  (d_side),
        .quot      (d_quot)
    );

    always_comb
    begin
        coin         = (d_mag == '0);
        m_tdata_next = '0;
        m_tdata_next[33:0] = {1'b0, d_mag} - {2'b0, d_side.rsum};
        for (int i = 0; i < 3; i++)
        begin
            if (coin)
            begin
                nrm = '0;
            end
            else if (d_side.neg[i])
            begin
                nrm = ~d_quot[i] + 1'b1;
            end
            else
            begin
                nrm = d_quot[i][sps_pkg::NormW-1] ? 16'h7FFF : d_quot[i];
            end
            m_tdata_next[34 + 16*i +: 16] = nrm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= coin;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[81:34] == '0)
        else $error("coincident result with nonzero normal");
    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[81:34] != '0)
        else $error("separated result with zero normal");
    a_cap_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == sps_pkg::REG_GHOST_CAP
        |=> cap_reg == $past(pwdata[30:0]))
        else $error("ghost cap write lost");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(d_valid) && $stable(d_mag))
        else $error("pipeline moved during stall");
`endif

endmodule

// File: bench/sphere_pair_separation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sphere_pair_separation_tb
// Drives sphere pairs through the separation pipeline under random stream
// idling and ghost cap settings, and checks every gap, normal and coincident
// flag against a behavioral model of the pipeline.
// ----------------------------------------------------------------------------
module sphere_pair_separation_tb;

    typedef struct {
        logic signed [sps_pkg::GapW-1:0]  gap;
        logic signed [sps_pkg::NormW-1:0] nx;
        logic signed [sps_pkg::NormW-1:0] ny;
        logic signed [sps_pkg::NormW-1:0] nz;
        logic                             coincident;
    } separation_t;

    class separation_scoreboard;
        logic [sps_pkg::RadiusW-1:0] ghost_cap;
        separation_t                 pending[$];
        int                          errors;

        function new();
            ghost_cap = sps_pkg::RadiusW'(sps_pkg::CapReset);
            errors    = 0;
        endfunction

        function logic [sps_pkg::RadiusW-1:0] eff_radius(logic [sps_pkg::RadiusW-1:0] r,
                                                         logic ghost, logic other_player);
            if (ghost && r > ghost_cap && !other_player)
                return ghost_cap;
            return r;
        endfunction

        function logic [sps_pkg::NormW-1:0] normal_comp(logic signed [sps_pkg::DiffW-1:0] d,
                                                        logic [sps_pkg::MagW-1:0] mag);
            logic [sps_pkg::DiffW-1:0] ad;
            logic [63:0]               q;
            ad = d[sps_pkg::DiffW-1] ? -d : d;
            q  = {31'd0, ad} * 64'd32768 / {31'd0, mag};
            if (d[sps_pkg::DiffW-1])
                return (q > 64'd32768) ? 16'sh8000 : -q[15:0];
            return (q > 64'd32767) ? 16'sh7fff : q[15:0];
        endfunction

        function void note_pair(logic [255:0] td, logic [3:0] tu);
            logic signed [sps_pkg::DiffW-1:0] d[3];
            logic [sps_pkg::DiffW-1:0]        a;
            logic [sps_pkg::SqW+1:0]          sq;
            logic [sps_pkg::MagW:0]           mag;
            logic [sps_pkg::MagW:0]           cand;
            logic [sps_pkg::RadiusW-1:0]      r1;
            logic [sps_pkg::RadiusW-1:0]      r2;
            separation_t                      e;
            sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = $signed({td[32*i+31], td[32*i +: 32]})
                     - $signed({td[32*(i+3)+31], td[32*(i+3) +: 32]});
                a = d[i][sps_pkg::DiffW-1] ? -d[i] : d[i];
                sq += {35'd0, a} * {35'd0, a};
            end
            mag = 0;
            for (int b = 33; b >= 0; b--)
            begin
                cand = mag | (34'd1 << b);
                if ({34'd0, cand} * {34'd0, cand} <= {2'd0, sq})
                    mag = cand;
            end
            r1 = eff_radius(td[192 +: 31], tu[0], tu[3]);
            r2 = eff_radius(td[223 +: 31], tu[1], tu[2]);
            e.gap = $signed({1'b0, mag}) - $signed({3'd0, r1}) - $signed({3'd0, r2});
            e.coincident = (mag == 0);
            if (mag == 0)
            begin
                e.nx = 0;
                e.ny = 0;
                e.nz = 0;
            end
            else
            begin
                e.nx = normal_comp(d[0], mag[sps_pkg::MagW-1:0]);
                e.ny = normal_comp(d[1], mag[sps_pkg::MagW-1:0]);
                e.nz = normal_comp(d[2], mag[sps_pkg::MagW-1:0]);
            end
            pending.push_back(e);
        endfunction

        task check_result(logic [87:0] td, logic tu);
            separation_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("result word with nothing pending", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (td[33:0] !== e.gap)
                report_mismatch("gap", td[33:0], e.gap);
            if (td[49:34] !== e.nx)
                report_mismatch("normal_x", td[49:34], e.nx);
            if (td[65:50] !== e.ny)
                report_mismatch("normal_y", td[65:50], e.ny);
            if (td[81:66] !== e.nz)
                report_mismatch("normal_z", td[81:66], e.nz);
            if (tu !== e.coincident)
                report_mismatch("coincident", tu, e.coincident);
        endtask

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        endtask
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [87:0]  m_tdata;
    logic         m_tuser;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    separation_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_stall = 0;
    int  hold_off = 0;
    longint cycles = 0;

    sphere_pair_separation i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic write_cap(logic [31:0] v);
        @(negedge clk);
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= {sps_pkg::REG_GHOST_CAP, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.ghost_cap = v[sps_pkg::RadiusW-1:0];
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic send_pair(logic [255:0] td, logic [3:0] tu);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= td;
        s_tuser  <= tu;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pair(td, tu);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic send_random();
        logic [255:0] td;
        int           mode;
        mode = $urandom_range(5);
        if (mode > 2)
            mode = 1;
        for (int i = 0; i < 3; i++)
            td[32*i +: 32] = rand_coord(mode);
        for (int i = 3; i < 6; i++)
            td[32*i +: 32] = ($urandom_range(9) == 0) ? td[32*(i-3) +: 32]
                           : ($urandom_range(3) == 0 ? td[32*(i-3) +: 32]
                                + ($urandom_range(200) - 100) : rand_coord(mode));
        td[192 +: 31] = $urandom_range(1) ? 31'($urandom()) : 31'($urandom_range(200000));
        td[223 +: 31] = $urandom_range(1) ? 31'($urandom()) : 31'($urandom_range(200000));
        td[254 +: 2]  = 0;
        send_pair(td, 4'($urandom()));
    endtask

    logic [255:0] dt;
    logic [31:0]  caps[5] = '{32'h0, 32'h7fff_ffff, 32'h0001_8000, 32'h0000_0001, 32'h0};

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        for (int k = 0; k < 24; k++)
        begin
            dt = '0;
            case (k % 8)
                1: for (int i = 0; i < 3; i++) dt[32*i +: 32] = 32'h7fff_ffff;
                2: for (int i = 3; i < 6; i++) dt[32*i +: 32] = 32'h8000_0000;
                3: begin
                    for (int i = 0; i < 3; i++) dt[32*i +: 32] = 32'h7fff_ffff;
                    for (int i = 3; i < 6; i++) dt[32*i +: 32] = 32'h8000_0000;
                end
                4: dt[31:0] = 32'h0001_0000;
                5: dt[127:96] = 32'h0000_0001;
                6: begin
                    dt[31:0] = 32'h8000_0000;
                    dt[127:96] = 32'h7fff_ffff;
                end
                7: dt[95:64] = 32'hffff_ffff;
                default: dt = '0;
            endcase
            dt[192 +: 31] = (k / 8 == 1) ? 31'h7fff_ffff : 31'(k * 40000);
            dt[223 +: 31] = (k / 8 == 2) ? 31'h7fff_ffff : 31'(k * 30000);
            send_pair(dt, 4'(k));
        end
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_cap(ph == 4 ? $urandom() : caps[ph]);
            case (ph % 4)
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                3: begin send_idle = 7;  recv_stall = 7;  end
                default: begin send_idle = 0;  recv_stall = 0;  end
            endcase
            if (ph == 0)
                hold_off = 300;
            for (int n = 0; n < 385; n++)
                send_random();
            drain();
        end
        write_cap(32'(sps_pkg::CapReset));

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sphere_pair_separation.f
src/sps_pkg.sv
src/sps_front.sv
src/sps_sqrt.sv
src/sps_div.sv
src/sphere_pair_separation.sv
bench/sphere_pair_separation_tb.sv
